/* hdl/ps2a_pkg.sv */
package ps2a_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 9;
  localparam int unsigned CharW = 7;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [CharW-1:0] char_t;

  // special bytes and modifier keys
  localparam byte_t BREAK_BASE  = 8'h80;
  localparam byte_t PREFIX_EXT  = 8'hE0;
  localparam byte_t PREFIX_IGN  = 8'hE1;
  localparam byte_t LSHIFT_CODE = 8'h2A;
  localparam byte_t RSHIFT_CODE = 8'h36;
  localparam byte_t LCTRL_CODE  = 8'h1D;
  localparam byte_t RCTRL_CODE  = 8'h38;
  localparam byte_t KEY_CAPS    = 8'h3A;

  // character rom covers codes below this
  localparam byte_t ROM_SIZE = 8'h54;

  localparam char_t MAP_REGULAR [0:83] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  localparam char_t MAP_SHIFT [0:83] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  // character for a non-extended press; caps together with shift uses the regular map
  function automatic char_t translate(byte_t key, logic shift, logic caps);
    char_t c;
    c = '0;
    if (key < ROM_SIZE) begin
      if (shift && !caps) begin
        c = MAP_SHIFT[key[6:0]];
      end else begin
        c = MAP_REGULAR[key[6:0]];
        if (caps && !shift && c >= 7'h61 && c <= 7'h7A) begin
          c[5] = 1'b0;
        end
      end
    end
    return c;
  endfunction

endpackage

/* hdl/ps2a_byte_if.sv */
interface ps2a_byte_if;
  import ps2a_pkg::*;

  logic  valid;
  logic  ready;
  byte_t scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

/* hdl/ps2a_event_if.sv */
interface ps2a_event_if;
  import ps2a_pkg::*;

  logic  valid;
  logic  ready;
  logic  event_valid;
  code_t key_code;
  logic  released;
  logic  left_shift;
  logic  right_shift;
  logic  left_ctrl;
  logic  right_ctrl;
  logic  caps_lock;
  char_t ascii_char;

  modport source (
    output valid, output event_valid, output key_code, output released,
    output left_shift, output right_shift, output left_ctrl, output right_ctrl,
    output caps_lock, output ascii_char, input ready
  );
  modport sink (
    input valid, input event_valid, input key_code, input released,
    input left_shift, input right_shift, input left_ctrl, input right_ctrl,
    input caps_lock, input ascii_char, output ready
  );
endinterface

/* hdl/ps2_set1_scancode_to_ascii_unit.sv */
// a result word is registered: it is on event_out in the cycle after its byte is taken
// throughput: one byte per cycle while the receiver keeps reading; the key state and result register update together
// a byte is taken whenever the result register is empty or being read in that cycle
// reset (rst, synchronous): clears the prefix flag, shift, ctrl and caps lock state
// and empties the result register
module ps2_set1_scancode_to_ascii_unit (
  input logic         clk,
  input logic         rst,
  ps2a_byte_if.sink   scan_in,
  ps2a_event_if.source event_out
);
  import ps2a_pkg::*;

  // key state
  logic ext_pending, ext_pending_next;
  logic lshift, lshift_next;
  logic rshift, rshift_next;
  logic lctrl, lctrl_next;
  logic rctrl, rctrl_next;
  logic caps, caps_next;

  // result register
  logic  out_valid;
  logic  res_event;
  code_t res_code;
  logic  res_rel;
  logic  res_lshift, res_rshift, res_lctrl, res_rctrl, res_caps;
  char_t res_char;

  // decode signals
  byte_t raw;
  byte_t key;
  logic  rel;
  logic  is_prefix;
  logic  accept;
  char_t chr;

  assign scan_in.ready = !out_valid || event_out.ready;
  assign accept        = scan_in.valid && scan_in.ready;
  assign raw           = scan_in.scan_byte;

  // split break codes and update modifier state
  always_comb begin
    rel         = (raw > BREAK_BASE) && (raw < PREFIX_EXT);
    key         = rel ? (raw - BREAK_BASE) : raw;
    is_prefix   = (key == PREFIX_EXT) || (key == PREFIX_IGN);
    lshift_next = (key == LSHIFT_CODE) ? !rel : lshift;
    rshift_next = (key == RSHIFT_CODE) ? !rel : rshift;
    lctrl_next  = (key == LCTRL_CODE) ? !rel : lctrl;
    rctrl_next  = (key == RCTRL_CODE) ? !rel : rctrl;
    caps_next   = (key == KEY_CAPS && !rel) ? !caps : caps;
    if (is_prefix) begin
      ext_pending_next = ext_pending || (key == PREFIX_EXT);
    end else begin
      ext_pending_next = 1'b0;
    end
    // character only for a plain press
    if (rel || ext_pending || is_prefix) begin
      chr = '0;
    end else begin
      chr = translate(key, lshift_next || rshift_next, caps_next);
    end
  end

  // key state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_pending <= 1'b0;
      lshift      <= 1'b0;
      rshift      <= 1'b0;
      lctrl       <= 1'b0;
      rctrl       <= 1'b0;
      caps        <= 1'b0;
    end else if (accept) begin
      ext_pending <= ext_pending_next;
      lshift      <= lshift_next;
      rshift      <= rshift_next;
      lctrl       <= lctrl_next;
      rctrl       <= rctrl_next;
      caps        <= caps_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_event  <= !is_prefix;
      res_code   <= is_prefix ? '0 : {ext_pending, key};
      res_rel    <= rel && !is_prefix;
      res_lshift <= lshift_next;
      res_rshift <= rshift_next;
      res_lctrl  <= lctrl_next;
      res_rctrl  <= rctrl_next;
      res_caps   <= caps_next;
      res_char   <= chr;
    end
  end

  assign event_out.valid       = out_valid;
  assign event_out.event_valid = res_event;
  assign event_out.key_code    = res_code;
  assign event_out.released    = res_rel;
  assign event_out.left_shift  = res_lshift;
  assign event_out.right_shift = res_rshift;
  assign event_out.left_ctrl   = res_lctrl;
  assign event_out.right_ctrl  = res_rctrl;
  assign event_out.caps_lock   = res_caps;
  assign event_out.ascii_char  = res_char;

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2a_pkg::*;

  // one decoded result word, in the order of the event interface
  typedef struct packed {
    logic  event_valid;
    code_t key_code;
    logic  released;
    logic  left_shift;
    logic  right_shift;
    logic  left_ctrl;
    logic  right_ctrl;
    logic  caps_lock;
    char_t ascii_char;
  } key_event_t;

  // directed row: mods are {lshift, rshift, lctrl, rctrl, caps}
  typedef struct packed {
    byte_t      scan;
    logic       typed;
    logic       valid;
    code_t      code;
    logic       rel;
    logic [4:0] mods;
    char_t      ch;
  } dir_row_t;

  localparam char_t LOWER_A  = 7'h61;
  localparam char_t LOWER_Z  = 7'h7A;
  localparam char_t CASE_GAP = 7'h20;

  localparam int DirRows = 26;
  localparam dir_row_t DIR_TABLE [DirRows] = '{
    // reset state, extremes of the byte range
    '{8'h00, 1'b1, 1'b1, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h02, 1'b1, 1'b1, 9'h002, 1'b0, 5'b00000, 7'h31},
    '{BREAK_BASE, 1'b1, 1'b1, 9'h080, 1'b0, 5'b00000, 7'h00},
    '{8'hFF, 1'b1, 1'b1, 9'h0FF, 1'b0, 5'b00000, 7'h00},
    '{8'hDF, 1'b1, 1'b1, 9'h05F, 1'b1, 5'b00000, 7'h00},
    // prefix, ignored byte keeps it armed, repeated prefix counts once
    '{PREFIX_EXT, 1'b1, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{PREFIX_IGN, 1'b1, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{PREFIX_EXT, 1'b1, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h1E, 1'b1, 1'b1, 9'h11E, 1'b0, 5'b00000, 7'h00},
    '{LSHIFT_CODE, 1'b1, 1'b1, 9'h02A, 1'b0, 5'b10000, 7'h00},
    // shift, caps with shift, caps alone
    '{8'h1E, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{KEY_CAPS, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h1E, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{LSHIFT_CODE | BREAK_BASE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h1E, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{RSHIFT_CODE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{KEY_CAPS | BREAK_BASE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{KEY_CAPS, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h0C, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    // modifiers reached through the prefix
    '{PREFIX_EXT, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{RSHIFT_CODE | BREAK_BASE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{LCTRL_CODE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{PREFIX_EXT, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{LCTRL_CODE | BREAK_BASE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{RCTRL_CODE, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00},
    '{8'h53, 1'b0, 1'b0, 9'h000, 1'b0, 5'b00000, 7'h00}
  };

  localparam byte_t MOD_KEYS [4] = '{LSHIFT_CODE, RSHIFT_CODE, LCTRL_CODE, RCTRL_CODE};

  logic clk;
  logic rst;

  ps2a_byte_if  scan_if ();
  ps2a_event_if event_if ();

  ps2_set1_scancode_to_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .scan_in   (scan_if),
    .event_out (event_if)
  );

  // decoder state as the block should hold it
  logic ext_armed = 1'b0;
  logic lshift_q  = 1'b0;
  logic rshift_q  = 1'b0;
  logic lctrl_q   = 1'b0;
  logic rctrl_q   = 1'b0;
  logic caps_q    = 1'b0;

  key_event_t pending_events [$];

  int phase        = 0;
  int src_idle_pct = 36;
  int snk_idle_pct = 69;
  int stall_left   = 0;
  bit stall_done   = 1'b0;

  int bytes_sent  = 0;
  int events_seen = 0;
  int prefix_seen = 0;
  int chars_seen  = 0;
  int errors      = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // decode one scan byte and advance the key state
  function automatic key_event_t decode_scan_byte(byte_t b);
    key_event_t ev;
    byte_t      k;
    logic       brk;
    logic       shifted;
    char_t      ch;
    ev  = '0;
    k   = b;
    brk = 1'b0;
    ch  = '0;
    if (b > BREAK_BASE && b < PREFIX_EXT) begin
      brk = 1'b1;
      k   = b - BREAK_BASE;
    end
    case (k)
      LSHIFT_CODE: lshift_q = !brk;
      RSHIFT_CODE: rshift_q = !brk;
      LCTRL_CODE:  lctrl_q = !brk;
      RCTRL_CODE:  rctrl_q = !brk;
      KEY_CAPS:    if (!brk) caps_q = !caps_q;
      PREFIX_EXT:  ext_armed = 1'b1;
      default: ;
    endcase
    if (k != PREFIX_EXT && k != PREFIX_IGN) begin
      ev.event_valid = 1'b1;
      ev.key_code    = {ext_armed, k};
      ev.released    = brk;
      // character only for a plain press inside the rom
      shifted = lshift_q | rshift_q;
      if (!brk && !ext_armed && k < ROM_SIZE) begin
        if (shifted && !caps_q) begin
          ch = MAP_SHIFT[k[6:0]];
        end else begin
          ch = MAP_REGULAR[k[6:0]];
          if (caps_q && !shifted && ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_GAP;
        end
      end
      ev.ascii_char = ch;
      ext_armed = 1'b0;
    end
    ev.left_shift  = lshift_q;
    ev.right_shift = rshift_q;
    ev.left_ctrl   = lctrl_q;
    ev.right_ctrl  = rctrl_q;
    ev.caps_lock   = caps_q;
    return ev;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // offer one byte, starting and ending at a falling edge
  task automatic send_byte(input byte_t b, input bit use_typed = 1'b0,
                           input key_event_t typed_ev = '0);
    key_event_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      scan_if.valid <= 1'b0;
      @(negedge clk);
    end
    scan_if.valid     <= 1'b1;
    scan_if.scan_byte <= b;
    do @(posedge clk); while (!scan_if.ready);
    pred = decode_scan_byte(b);
    pending_events.push_back(use_typed ? typed_ev : pred);
    bytes_sent++;
    @(negedge clk);
  endtask

  // press and release of one key, sometimes behind the extended prefix
  task automatic type_stroke();
    byte_t k;
    bit    ext;
    k   = byte_t'($urandom_range(8'h5F, 8'h01));
    ext = ($urandom_range(99) < 15);
    if (ext) send_byte(PREFIX_EXT);
    send_byte(k);
    if (ext) send_byte(PREFIX_EXT);
    send_byte(k | BREAK_BASE);
  endtask

  // receiver side, with one long hold-off at the start of the last phase
  always @(negedge clk) begin
    if (phase == 2 && !stall_done) begin
      stall_left = 64;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      event_if.ready <= 1'b0;
      stall_left--;
    end else begin
      event_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && event_if.valid && event_if.ready) begin
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected word", event_if.key_code, 0);
      end else begin
        want = pending_events.pop_front();
        if (event_if.event_valid !== want.event_valid)
          note_mismatch("event_valid", event_if.event_valid, want.event_valid);
        if (event_if.key_code !== want.key_code)
          note_mismatch("key_code", event_if.key_code, want.key_code);
        if (event_if.released !== want.released)
          note_mismatch("released", event_if.released, want.released);
        if (event_if.left_shift !== want.left_shift)
          note_mismatch("left_shift", event_if.left_shift, want.left_shift);
        if (event_if.right_shift !== want.right_shift)
          note_mismatch("right_shift", event_if.right_shift, want.right_shift);
        if (event_if.left_ctrl !== want.left_ctrl)
          note_mismatch("left_ctrl", event_if.left_ctrl, want.left_ctrl);
        if (event_if.right_ctrl !== want.right_ctrl)
          note_mismatch("right_ctrl", event_if.right_ctrl, want.right_ctrl);
        if (event_if.caps_lock !== want.caps_lock)
          note_mismatch("caps_lock", event_if.caps_lock, want.caps_lock);
        if (event_if.ascii_char !== want.ascii_char)
          note_mismatch("ascii_char", event_if.ascii_char, want.ascii_char);
        if (want.event_valid) events_seen++;
        else prefix_seen++;
        if (want.ascii_char != '0) chars_seen++;
      end
    end
  end

  initial begin
    dir_row_t   row;
    key_event_t typed_ev;
    byte_t      k;
    int         pick;
    int         target;
    int         n;
    int         i;

    rst                = 1'b1;
    scan_if.valid      = 1'b0;
    scan_if.scan_byte  = '0;
    event_if.ready     = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < DirRows; i++) begin
      row      = DIR_TABLE[i];
      typed_ev = {row.valid, row.code, row.rel, row.mods, row.ch};
      send_byte(row.scan, row.typed, typed_ev);
    end

    // random part, three idling profiles
    for (int p = 0; p < 3; p++) begin
      phase        = p;
      src_idle_pct = (p == 0) ? 36 : (p == 1) ? 69 : 0;
      snk_idle_pct = (p == 0) ? 69 : (p == 1) ? 36 : 0;
      target       = bytes_sent + 510;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          // hold a modifier while typing a few keys
          k = MOD_KEYS[$urandom_range(3)];
          send_byte(k);
          n = $urandom_range(4, 1);
          repeat (n) type_stroke();
          send_byte(k | BREAK_BASE);
        end else if (pick < 25) begin
          send_byte(KEY_CAPS);
          send_byte(KEY_CAPS | BREAK_BASE);
        end else if (pick < 75) begin
          type_stroke();
        end else if (pick < 82) begin
          send_byte($urandom_range(1) ? PREFIX_EXT : PREFIX_IGN);
        end else begin
          send_byte(byte_t'($urandom_range(255)));
        end
      end
    end
    scan_if.valid <= 1'b0;

    // drain
    for (i = 0; i < 5000 && pending_events.size() > 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_events.size() > 0) begin
      note_mismatch("words never delivered", 0, pending_events.size());
    end

    $display("covered %0d scan bytes: %0d key events, %0d with a character, %0d prefix words",
             bytes_sent, events_seen, chars_seen, prefix_seen);
    $display("idling on both sides, swapped, none, and one long receiver hold-off; %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
